FILE: src/mexp_pkg.sv
// Shared types and constants for the modular exponentiation core.
package mexp_pkg;

  // Prime modulus and the constants of its Barrett reduction
  localparam logic [29:0] PRIME  = 30'd1000000007;
  localparam logic [31:0] PRIME2 = 32'd2000000014;
  // floor(2^60 / PRIME)
  localparam logic [30:0] MU     = 31'd1152921496;
  // 2^30 mod PRIME, used to fold the upper half of a wide base
  localparam logic [29:0] C30    = 30'd73741817;

  // One modular multiply request: (a * b + addend) mod PRIME
  typedef struct packed {
    logic        go;
    logic [29:0] a;
    logic [29:0] b;
    logic [32:0] addend;
  } mexp_req_t;

  // Reduced result, marked by a one-cycle done pulse
  typedef struct packed {
    logic        done;
    logic [29:0] value;
  } mexp_rsp_t;

endpackage

FILE: src/mexp_mulred.sv
// Shared multiplier with Barrett reduction modulo the prime, five steps per request.
module mexp_mulred (
  input  logic              clk,
  input  logic              rst,
  input  mexp_pkg::mexp_req_t req,
  output mexp_pkg::mexp_rsp_t rsp
);
  import mexp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PROD = 3'd1;
  localparam logic [2:0] ST_FOLD = 3'd2;
  localparam logic [2:0] ST_EST  = 3'd3;
  localparam logic [2:0] ST_QP   = 3'd4;
  localparam logic [2:0] ST_CORR = 3'd5;

  logic [2:0]  state;
  logic [29:0] opa;
  logic [29:0] opb;
  logic [32:0] addend;
  logic [61:0] prod;
  logic [59:0] x;
  logic [30:0] mul_a;
  logic [30:0] mul_b;
  logic [61:0] mul_p;
  logic [31:0] rem;
  logic [31:0] rem_p;
  logic [31:0] rem_2p;
  logic [29:0] rem_fix;

  // Select multiplier operands: a*b, then quotient estimate, then quotient times prime
  always_comb begin
    case (state)
      ST_EST: begin
        mul_a = x[59:29];
        mul_b = MU;
      end
      ST_QP: begin
        mul_a = prod[61:31];
        mul_b = {1'b0, PRIME};
      end
      default: begin
        mul_a = {1'b0, opa};
        mul_b = {1'b0, opb};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Remainder is below three times the prime; subtract it out at most twice
  assign rem    = x[31:0] - prod[31:0];
  assign rem_p  = rem - {2'b00, PRIME};
  assign rem_2p = rem - PRIME2;

  always_comb begin
    if (rem >= PRIME2) begin
      rem_fix = rem_2p[29:0];
    end else if (rem >= {2'b00, PRIME}) begin
      rem_fix = rem_p[29:0];
    end else begin
      rem_fix = rem[29:0];
    end
  end

  // Sequence one request through the shared multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.go) begin
            state <= ST_PROD;
          end
        end
        ST_PROD: state <= ST_FOLD;
        ST_FOLD: state <= ST_EST;
        ST_EST:  state <= ST_QP;
        ST_QP:   state <= ST_CORR;
        ST_CORR: begin
          rsp.value <= rem_fix;
          rsp.done  <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.go) begin
      opa    <= req.a;
      opb    <= req.b;
      addend <= req.addend;
    end
    if (state == ST_PROD || state == ST_EST || state == ST_QP) begin
      prod <= mul_p;
    end
    if (state == ST_FOLD) begin
      x <= prod[59:0] + {27'd0, addend};
    end
  end

endmodule

FILE: src/modular_exponentiation_core.sv
// Top level of the modular exponentiation core: square-and-multiply sequencer.
//
// Computes base ** exponent mod 1000000007 with right-to-left square and multiply,
// scanning the low EXP_BITS exponent bits. An item is taken when start is high and
// busy is low; busy stays high until the result appears on power_mod with done high
// for one cycle, which the receiver must take then. All arithmetic goes through one
// shared 31x31 multiplier with Barrett reduction. An item first reduces the base with
// two modular multiplies; then each exponent bit below the highest set one costs a
// square, and each set bit a multiply, so a zero exponent needs only the base
// reduction.
module modular_exponentiation_core #(
  parameter int EXP_BITS = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [62:0] base,
  input  logic [62:0] exponent,
  output logic        done,
  output logic [29:0] power_mod
);
  import mexp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BHI   = 3'd1;
  localparam logic [2:0] ST_BFOLD = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_MULT  = 3'd4;
  localparam logic [2:0] ST_SQR   = 3'd5;

  logic [2:0]          state;
  logic [EXP_BITS-1:0] e;
  logic [29:0]         acc;
  logic [29:0]         sq;
  logic [29:0]         base_lo;
  mexp_req_t           req;
  mexp_rsp_t           rsp;

  mexp_mulred u_mulred (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign busy = (state != ST_IDLE);

  // Sequence base reduction, then one square per exponent bit below the top set bit and a multiply per set bit
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      req.go <= 1'b0;
    end else begin
      done   <= 1'b0;
      req.go <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            // Reduce the upper base bits first
            base_lo    <= base[29:0];
            e          <= exponent[EXP_BITS-1:0];
            req.go     <= 1'b1;
            req.a      <= '0;
            req.b      <= '0;
            req.addend <= base[62:30];
            state      <= ST_BHI;
          end
        end
        ST_BHI: begin
          if (rsp.done) begin
            // Fold: hi * 2^30 + lo
            req.go     <= 1'b1;
            req.a      <= rsp.value;
            req.b      <= C30;
            req.addend <= {3'd0, base_lo};
            state      <= ST_BFOLD;
          end
        end
        ST_BFOLD: begin
          if (rsp.done) begin
            sq    <= rsp.value;
            acc   <= 30'd1;
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (e == '0) begin
            power_mod <= acc;
            done      <= 1'b1;
            state     <= ST_IDLE;
          end else if (e[0]) begin
            req.go     <= 1'b1;
            req.a      <= acc;
            req.b      <= sq;
            req.addend <= '0;
            state      <= ST_MULT;
          end else begin
            req.go     <= 1'b1;
            req.a      <= sq;
            req.b      <= sq;
            req.addend <= '0;
            state      <= ST_SQR;
          end
        end
        ST_MULT: begin
          if (rsp.done) begin
            acc <= rsp.value;
            if ((e >> 1) == '0) begin
              // No bits left: skip the final square
              e     <= '0;
              state <= ST_STEP;
            end else begin
              req.go     <= 1'b1;
              req.a      <= sq;
              req.b      <= sq;
              req.addend <= '0;
              state      <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          if (rsp.done) begin
            sq    <= rsp.value;
            e     <= e >> 1;
            state <= ST_STEP;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/mexp_checker.sv
// Port-level checker for the modular exponentiation core, bound to the top level.
module mexp_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [29:0] power_mod
);
  import mexp_pkg::*;

  // Result is always a reduced residue
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (power_mod < PRIME))
    else $error("power_mod not below the prime");

  // An accepted item makes the core busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  // A result ends exactly one busy period
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("done without a finished busy period");

  // Busy drops only with a result
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .power_mod (power_mod)
);

FILE: tb/sv/mexp_checker.sv
// Checker for the modular exponentiation core: predicts each power and compares results.
`timescale 1ns / 1ps

module mexp_scoreboard #(
  parameter int EXP_BITS = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [62:0] base,
  input  logic [62:0] exponent,
  input  logic        done,
  input  logic [29:0] power_mod,
  output int          failures,
  output int          pending
);
  import mexp_pkg::*;

  typedef struct {
    logic [62:0] base;
    logic [62:0] exponent;
    logic [29:0] power;
  } power_item_t;

  power_item_t power_q[$];

  // Right-to-left square and multiply, both operands kept below the prime
  function automatic logic [29:0] expected_power(input logic [62:0] b, input logic [62:0] e);
    bit [63:0] modulus;
    bit [63:0] acc;
    bit [63:0] square;
    modulus = 64'(PRIME);
    acc     = 64'd1;
    square  = {1'b0, b} % modulus;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (e[i]) acc = (acc * square) % modulus;
      square = (square * square) % modulus;
    end
    return acc[29:0];
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Retire the oldest expectation on each result, then queue the newly accepted item
  always @(posedge clk) begin
    power_item_t head;
    power_item_t item;
    if (!rst) begin
      if (done) begin
        if (power_q.size() == 0) begin
          note_failure($sformatf("unexpected result power_mod=%0d", power_mod));
        end else begin
          head = power_q.pop_front();
          if (power_mod !== head.power)
            note_failure($sformatf("base=%0d exponent=%0d expected %0d got %0d",
                                   head.base, head.exponent, head.power, power_mod));
        end
      end
      if (start && !busy) begin
        item.base     = base;
        item.exponent = exponent;
        item.power    = expected_power(base, exponent);
        power_q       = {power_q, item};
      end
    end
    pending <= power_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the modular exponentiation core: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
  import mexp_pkg::*;

  localparam int EXP_BITS     = 63;
  localparam int RANDOM_ITEMS = 1850;
  localparam int DRAIN_CYCLES = 1000;
  localparam int STALL_LIMIT  = 8000;
  localparam logic [62:0] ALL_ONES = '1;
  localparam logic [62:0] TOP_BIT  = 63'd1 << 62;
  localparam logic [62:0] MODULUS  = 63'(PRIME);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [62:0] base = '0;
  logic [62:0] exponent = '0;
  logic        busy;
  logic        done;
  logic [29:0] power_mod;
  int          failures;
  int          pending;
  int          stall_cycles = 0;
  int          burst_left = 0;

  always #10 clk = ~clk;

  modular_exponentiation_core #(.EXP_BITS(EXP_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .base      (base),
    .exponent  (exponent),
    .done      (done),
    .power_mod (power_mod)
  );

  mexp_scoreboard #(.EXP_BITS(EXP_BITS)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .base      (base),
    .exponent  (exponent),
    .done      (done),
    .power_mod (power_mod),
    .failures  (failures),
    .pending   (pending)
  );

  function automatic logic [62:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  // Mostly short exponents so the run stays short; a share uses all 63 bits
  function automatic logic [62:0] pick_exponent();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return rand63() >> (63 - $urandom_range(1, 12));
    if (pick < 80) return rand63() >> (63 - $urandom_range(13, 32));
    if (pick < 85) return '0;
    return rand63();
  endfunction

  // Mix full-width bases with small ones and ones near multiples of the prime
  function automatic logic [62:0] pick_base();
    int          pick;
    logic [62:0] mult;
    pick = $urandom_range(0, 99);
    mult = 63'($urandom) * MODULUS;
    if (pick < 40) return rand63();
    if (pick < 55) return 63'($urandom_range(0, 20));
    if (pick < 70) return mult;
    if (pick < 85) return mult + 63'($urandom_range(1, 3)) - 63'(($urandom_range(0, 1)) * 2);
    return 63'($urandom_range(0, 32'h3FFF_FFFF));
  endfunction

  // Idle for a random gap, sometimes only once the core is free, then hold the item until taken
  task automatic send_item(input logic [62:0] b, input logic [62:0] e);
    int gap;
    bit wait_idle;
    gap       = $urandom_range(0, 9);
    wait_idle = ($urandom_range(0, 3) == 0);
    if (burst_left > 0) begin
      burst_left--;
      gap       = 0;
      wait_idle = 1'b0;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(5, 40);
    end
    if (gap > 0 || wait_idle) begin
      start    <= 1'b0;
      base     <= rand63();
      exponent <= rand63();
      do @(posedge clk); while (wait_idle && busy);
      for (int i = 1; i < gap; i++) @(posedge clk);
    end
    start    <= 1'b1;
    base     <= b;
    exponent <= e;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold until every queued item has produced its result
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Abort when neither an item nor a result moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Zero exponent, including zero and prime-multiple bases
    send_item(63'd0, 63'd0);
    send_item(MODULUS, 63'd0);
    send_item(ALL_ONES, 63'd0);
    // Bases that are multiples of the prime with nonzero exponents
    send_item(MODULUS, 63'd1);
    send_item(MODULUS * 63'd2, ALL_ONES);
    send_item(63'(32'hFFFF_FFFF) * MODULUS, 63'd12345);
    send_item(63'd0, 63'd1);
    // Field extremes
    send_item(63'd1, ALL_ONES);
    send_item(ALL_ONES, ALL_ONES);
    send_item(ALL_ONES, 63'd1);
    send_item(ALL_ONES, TOP_BIT);
    send_item(TOP_BIT, 63'd5);
    send_item(63'd2, TOP_BIT);
    // Values around the prime and small powers of two
    send_item(MODULUS - 63'd1, 63'd2);
    send_item(MODULUS - 63'd1, ALL_ONES);
    send_item(MODULUS + 63'd1, 63'd12345);
    send_item(63'd2, 63'd30);
    send_item(63'd2, 63'd62);
    // Fermat identity and modular inverse
    send_item(63'd12345, MODULUS - 63'd1);
    send_item(63'd3, MODULUS - 63'd2);

    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) send_item(pick_base(), pick_exponent());

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
